[hdl/acd_pkg.sv]
// Shared types and constants for the command APDU decoder.
`timescale 1ns / 1ps
`default_nettype none

package acd_pkg;

  localparam int DataW      = 8;
  localparam int TotW       = 17;
  localparam int LcW        = 16;
  localparam int LeW        = 17;
  localparam int HdrW       = 32;
  localparam int TrailW     = 24;
  localparam int SDataW     = 32;
  localparam int MDataW     = 80;

  // queue depth, power of two
  localparam int AcdFifoDepth = 4;
  localparam int AcdPtrW      = $clog2(AcdFifoDepth);
  localparam int AcdCntW      = $clog2(AcdFifoDepth + 1);

  localparam logic [LeW-1:0] LeShortZero = LeW'(256);
  localparam logic [LeW-1:0] LeExtZero   = LeW'(65536);

  typedef enum logic [1:0] {
    FormAbsent,
    FormShort,
    FormExt
  } acd_form_e;

  // one queue word: an optional data byte and an optional end-of-APDU summary
  typedef struct packed {
    logic              has_data;
    logic [DataW-1:0]  data;
    logic              has_sum;
    logic [HdrW-1:0]   hdr;
    logic [LcW-1:0]    lc;
    logic [TrailW-1:0] trail;
    logic [1:0]        tcnt;
    acd_form_e         form;
    logic              err;
  } acd_entry_t;

endpackage

`default_nettype wire

[hdl/acd_front.sv]
// Front end: accepts APDU bytes, tracks the parse state and queues results.
`timescale 1ns / 1ps
`default_nettype none

module acd_front
  import acd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [DataW-1:0]  data_byte_i,
  input  wire logic [TotW-1:0]   total_length_i,
  input  wire logic              last_byte_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output acd_entry_t             entry_o
);

  typedef enum logic [2:0] {
    PhHeader,
    PhLc1,
    PhLcHi,
    PhLcLo,
    PhData,
    PhTrail,
    PhSkip
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [TotW-1:0]   pos_q, pos_d;
  logic [TotW-1:0]   total_q, total_d;
  logic [TotW-1:0]   tm5_q, tm5_d;
  logic [TotW-1:0]   tm7_q, tm7_d;
  logic [HdrW-1:0]   hdr_q, hdr_d;
  acd_form_e         form_q, form_d;
  logic [LcW-1:0]    lc_q, lc_d;
  logic [LcW-1:0]    left_q, left_d;
  logic [TrailW-1:0] trail_q, trail_d;
  logic [1:0]        tcnt_q, tcnt_d;
  logic              err_q, err_d;

  logic              accept;
  logic              first;
  logic [TotW-1:0]   t_cur;
  logic [TotW:0]     short_diff;
  logic [LcW-1:0]    ext_lc;
  logic [TotW:0]     ext_diff;
  logic              short_ok;
  logic              ext_ok;
  logic              len_match;
  logic              has_data;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign first      = (pos_q == '0);
  assign t_cur      = first ? total_length_i : total_q;
  assign short_diff = {1'b0, tm5_q} - {{(TotW + 1 - DataW){1'b0}}, data_byte_i};
  assign ext_lc     = {lc_q[LcW-1:DataW], data_byte_i};
  assign ext_diff   = {1'b0, tm7_q} - {{(TotW + 1 - LcW){1'b0}}, ext_lc};
  assign short_ok   = !short_diff[TotW] && (short_diff[TotW-1:2] == '0);
  assign ext_ok     = !ext_diff[TotW] && (ext_diff[TotW-1:2] == '0);
  assign len_match  = (({1'b0, pos_q} + (TotW + 1)'(1)) == {1'b0, t_cur});

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    total_d  = total_q;
    tm5_d    = tm5_q;
    tm7_d    = tm7_q;
    hdr_d    = hdr_q;
    form_d   = form_q;
    lc_d     = lc_q;
    left_d   = left_q;
    trail_d  = trail_q;
    tcnt_d   = tcnt_q;
    err_d    = err_q;
    has_data = 1'b0;

    if (accept) begin
      if (first) begin
        total_d = total_length_i;
        tm5_d   = total_length_i - TotW'(5);
        tm7_d   = total_length_i - TotW'(7);
        if (total_length_i < TotW'(4)) begin
          err_d = 1'b1;
        end
      end
      if (pos_q[TotW-1:2] == '0) begin
        case (pos_q[1:0])
          2'd0:    hdr_d[31:24] = data_byte_i;
          2'd1:    hdr_d[23:16] = data_byte_i;
          2'd2:    hdr_d[15:8]  = data_byte_i;
          default: hdr_d[7:0]   = data_byte_i;
        endcase
      end

      if (pos_q >= t_cur) begin
        err_d   = 1'b1;
        phase_d = PhSkip;
      end else begin
        case (phase_q)
          PhHeader: begin
            if (pos_q == TotW'(3)) begin
              if (err_q) begin
                phase_d = PhSkip;
              end else if (total_q == TotW'(4)) begin
                phase_d = PhTrail;
              end else begin
                phase_d = PhLc1;
              end
            end
          end
          PhLc1: begin
            if ((total_q == TotW'(5)) ||
                ((total_q == TotW'(7)) && (data_byte_i == '0))) begin
              phase_d = PhTrail;
              trail_d = {{(TrailW - DataW){1'b0}}, data_byte_i};
              tcnt_d  = 2'd1;
            end else if (data_byte_i != '0) begin
              form_d = FormShort;
              lc_d   = {{(LcW - DataW){1'b0}}, data_byte_i};
              left_d = {{(LcW - DataW){1'b0}}, data_byte_i};
              if (short_ok) begin
                phase_d = PhData;
              end else begin
                err_d   = 1'b1;
                phase_d = PhSkip;
              end
            end else if (total_q < TotW'(7)) begin
              err_d   = 1'b1;
              phase_d = PhSkip;
            end else begin
              form_d  = FormExt;
              phase_d = PhLcHi;
            end
          end
          PhLcHi: begin
            lc_d    = {data_byte_i, {DataW{1'b0}}};
            phase_d = PhLcLo;
          end
          PhLcLo: begin
            lc_d   = ext_lc;
            left_d = ext_lc;
            if (ext_ok) begin
              phase_d = (ext_lc != '0) ? PhData : PhTrail;
            end else begin
              err_d   = 1'b1;
              phase_d = PhSkip;
            end
          end
          PhData: begin
            has_data = 1'b1;
            left_d   = left_q - LcW'(1);
            if (left_q == LcW'(1)) begin
              phase_d = PhTrail;
            end
          end
          PhTrail: begin
            trail_d = {trail_q[TrailW-DataW-1:0], data_byte_i};
            if (tcnt_q != 2'd3) begin
              tcnt_d = tcnt_q + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end

      if (pos_q != '1) begin
        pos_d = pos_q + TotW'(1);
      end
    end

    entry_o.has_data = has_data;
    entry_o.data     = data_byte_i;
    entry_o.has_sum  = last_byte_i;
    entry_o.hdr      = hdr_d;
    entry_o.lc       = lc_d;
    entry_o.trail    = trail_d;
    entry_o.tcnt     = tcnt_d;
    entry_o.form     = form_d;
    entry_o.err      = err_d || !len_match;
    push_o           = accept && (has_data || last_byte_i);

    // APDU closed: back to the idle values
    if (accept && last_byte_i) begin
      phase_d = PhHeader;
      pos_d   = '0;
      total_d = '0;
      tm5_d   = '0;
      tm7_d   = '0;
      hdr_d   = '0;
      form_d  = FormAbsent;
      lc_d    = '0;
      left_d  = '0;
      trail_d = '0;
      tcnt_d  = '0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= '0;
      total_q <= '0;
      tm5_q   <= '0;
      tm7_q   <= '0;
      hdr_q   <= '0;
      form_q  <= FormAbsent;
      lc_q    <= '0;
      left_q  <= '0;
      trail_q <= '0;
      tcnt_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      total_q <= total_d;
      tm5_q   <= tm5_d;
      tm7_q   <= tm7_d;
      hdr_q   <= hdr_d;
      form_q  <= form_d;
      lc_q    <= lc_d;
      left_q  <= left_d;
      trail_q <= trail_d;
      tcnt_q  <= tcnt_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

[hdl/acd_fifo.sv]
// Short queue of result words between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module acd_fifo
  import acd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire acd_entry_t  entry_i,
  input  wire logic        pop_i,
  output acd_entry_t       head_o,
  output logic             valid_o,
  output logic             full_o
);

  acd_entry_t           mem_q [AcdFifoDepth];
  logic [AcdPtrW-1:0]   wr_q, wr_d;
  logic [AcdPtrW-1:0]   rd_q, rd_d;
  logic [AcdCntW-1:0]   cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == AcdCntW'(AcdFifoDepth));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + AcdPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + AcdPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + AcdCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - AcdCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[hdl/acd_back.sv]
// Back end: decodes Le, finishes the checks and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module acd_back
  import acd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire acd_entry_t        head_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [MDataW-1:0]      m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic              vld_q, vld_d;
  logic              part_q, part_d;
  logic [MDataW-1:0] data_q, data_d;
  logic              user_q, user_d;
  logic              last_q, last_d;

  logic              load;
  logic              fmt_err;
  logic [LeW-1:0]    le_val;
  logic [15:0]       le16;
  logic [LcW-1:0]    dlen;
  logic [LeW-1:0]    elen;

  assign le16 = head_i.trail[15:0];

  always_comb begin
    fmt_err = head_i.err;
    le_val  = '0;
    case (head_i.tcnt)
      2'd0: begin
      end
      2'd1: begin
        le_val = (head_i.trail[7:0] == '0) ? LeShortZero :
                 {{(LeW - 8){1'b0}}, head_i.trail[7:0]};
        if (head_i.form == FormExt) begin
          fmt_err = 1'b1;
        end
      end
      default: begin
        le_val = (le16 == '0) ? LeExtZero : {1'b0, le16};
        if ((head_i.tcnt == 2'd2) && (head_i.form != FormExt)) begin
          fmt_err = 1'b1;
        end
        if ((head_i.tcnt == 2'd3) &&
            ((head_i.trail[23:16] != '0) || (head_i.form == FormShort))) begin
          fmt_err = 1'b1;
        end
        if ((head_i.lc < LcW'(256)) && (le16 != '0) && (le16 <= 16'd256)) begin
          fmt_err = 1'b1;
        end
      end
    endcase
    dlen = fmt_err ? '0 : head_i.lc;
    elen = fmt_err ? '0 : le_val;
  end

  assign load = head_valid_i && (!vld_q || m_axis_tready);

  always_comb begin
    vld_d  = vld_q;
    part_d = part_q;
    data_d = data_q;
    user_d = user_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = 1'b1;
      if (head_i.has_data && !part_q) begin
        data_d = {{(MDataW - DataW){1'b0}}, head_i.data};
        user_d = 1'b0;
        last_d = 1'b0;
        if (head_i.has_sum) begin
          part_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        data_d = {{(MDataW - 74){1'b0}}, fmt_err, elen, dlen,
                  head_i.hdr[7:0], head_i.hdr[15:8], head_i.hdr[23:16],
                  head_i.hdr[31:24], {DataW{1'b0}}};
        user_d = 1'b1;
        last_d = 1'b1;
        part_d = 1'b0;
        pop_o  = 1'b1;
      end
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      part_q <= 1'b0;
      data_q <= '0;
      user_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      part_q <= part_d;
      data_q <= data_d;
      user_q <= user_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

[hdl/apdu_command_decoder_top.sv]
// Top level of the command APDU decoder.
//
// Input stream: one APDU byte per word. tdata carries the byte and the total
// APDU length (read with the first byte); tlast marks the final byte.
// Output stream: tuser low is a command data byte passed through, tuser high
// is the summary (CLA, INS, P1, P2, Lc, Le, error flag), sent with tlast.
// One input word is taken per cycle while the queue is not full. A data byte or
// a summary passes through the queue and then the output register before it is
// valid on the output; when the final byte is also a data byte, the data word
// comes first and the summary after it.
// The front end updates the parse state for each accepted byte; a four-entry
// queue and the output register let input and output stall independently.
// When the receiver stalls, the queue fills and tready drops once it is full.
// Reset empties the queue and output register and returns the parser to
// waiting for a header byte.
`timescale 1ns / 1ps
`default_nettype none

module apdu_command_decoder_top
  import acd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] data_byte, [24:8] total_length, [31:25] zero
  input  wire logic [SDataW-1:0] s_axis_tdata,
  input  wire logic              s_axis_tlast,   // last_byte
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [7:0] payload_byte, [15:8] class_byte, [23:16] instruction_byte,
  // [31:24] param_one, [39:32] param_two, [55:40] data_length,
  // [72:56] expected_length, [73] format_error, [79:74] zero
  output logic [MDataW-1:0]      m_axis_tdata,
  output logic                   m_axis_tuser,   // result_kind
  output logic                   m_axis_tlast    // end_of_apdu
);

  logic       push;
  logic       pop;
  logic       full;
  logic       head_valid;
  acd_entry_t entry;
  acd_entry_t head;

  acd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .data_byte_i    (s_axis_tdata[7:0]),
    .total_length_i (s_axis_tdata[24:8]),
    .last_byte_i    (s_axis_tlast),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  acd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .full_o  (full)
  );

  acd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[hdl/acd_checker.sv]
// Port-level checks on the command APDU decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module acd_checker
  import acd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [MDataW-1:0] m_axis_tdata,
  input wire logic              m_axis_tuser,
  input wire logic              m_axis_tlast
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // only summaries close an APDU, and data words carry nothing but the byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("tlast does not match summary kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[MDataW-1:8] == '0))
    else $error("data word has nonzero upper fields");

  // a flagged summary reports no lengths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[73] |-> (m_axis_tdata[72:40] == '0))
    else $error("error summary carries lengths");

  // Le never above 65536
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[72] |-> (m_axis_tdata[71:56] == '0))
    else $error("expected length out of range");

endmodule

bind apdu_command_decoder_top acd_checker u_acd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
